>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define AST_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/pat_pkg.sv
// Package: constants and transaction types of the PDU ack tracking table.
package pat_pkg;

  localparam int unsigned CAPACITY  = 128;
  localparam int unsigned IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned ID_W      = 32;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned TTL_W     = 16;
  localparam int unsigned ENTRY_W   = ID_W + TIME_W;

  localparam logic [TTL_W-1:0] TTL_RESET = 16'd3000;

  // opcodes
  localparam logic [1:0] OP_REG   = 2'd0;
  localparam logic [1:0] OP_ACK   = 2'd1;
  localparam logic [1:0] OP_SWEEP = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ID_W-1:0]   pdu_id;
    logic [TIME_W-1:0] now_ms;
  } pat_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] expired_count;
  } pat_out_t;

endpackage

>>> rtl/pat_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/pdu_ack_tracking_table_top.sv
// Top level: PDU ack tracking table with a sequential scan over one table RAM.
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+----------------------------
//  request  | start (in), busy (out)           | req_i  : pat_in_t
//  result   | done_o strobe, one cycle         | res_o  : pat_out_t
//  config   | cfg_valid_i / cfg_ready_o        | cfg_data_i : ttl_ms
//
// A request transaction is taken when start is high and busy is low.
// Register (nonzero id), ack and sweep walk every table entry through the
// single read port of the table RAM, one entry per cycle in S_SCAN, then
// pass through S_LAST (drain) and S_COMMIT; done_o follows, and a new
// request is taken in that same cycle.
// Register with id 0 and the unused opcode report in the next cycle.
// Reset clears all valid bits and the count at once; no clearing pass.
// The result strobe cannot be stalled; the config port is always ready.
module pdu_ack_tracking_table_top
  import pat_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  pat_in_t          req_i,
  output logic             done_o,
  output pat_out_t         res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [TTL_W-1:0] cfg_data_i
);

`include "assert_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_COMMIT
  } state_e;

  state_e             state_q;
  logic [TTL_W-1:0]   ttl_q;
  logic [1:0]         op_q;
  logic [ID_W-1:0]    id_q;
  logic [TIME_W-1:0]  now_q;

  logic [CAPACITY-1:0] valid_q;    // per-slot valid bits, flops
  logic [CNT_W-1:0]    cnt_q;      // occupied slots

  logic [IDX_W-1:0]  rd_idx_q;     // address issued to the RAM
  logic [IDX_W-1:0]  cmp_idx_q;    // slot whose data is on rdata this cycle
  logic              cmp_act_q;    // rdata holds a slot to evaluate

  logic              match_q;      // register: duplicate seen / ack: slot removed
  logic              free_found_q;
  logic [IDX_W-1:0]  free_idx_q;   // lowest free slot
  logic [7:0]        removed_q;    // saturating sweep count

  logic              done_q;
  pat_out_t          res_q;

  // table RAM
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ID_W-1:0]    rd_id;
  logic [TIME_W-1:0]  rd_time;

  // shared compare unit
  logic              slot_live;
  logic              id_eq;
  logic [TIME_W:0]   age;
  logic              expired;
  logic              store;

  assign rd_id   = ram_rdata[TIME_W +: ID_W];
  assign rd_time = ram_rdata[TIME_W-1:0];

  assign slot_live = cmp_act_q && valid_q[cmp_idx_q];
  assign id_eq     = (rd_id == id_q);
  // borrow bit set means the sent time is in the future: never expires
  assign age       = {1'b0, now_q} - {1'b0, rd_time};
  assign expired   = !age[TIME_W] && (age[TIME_W-1:0] > {{(TIME_W-TTL_W){1'b0}}, ttl_q});

  // commit of a register transaction that stores a new entry
  assign store  = (state_q == S_COMMIT) && (op_q == OP_REG) && !match_q &&
                  (cnt_q != CNT_W'(CAPACITY));
  assign ram_we = store;

  pat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx_q),
    .wdata_i ({id_q, now_q}),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ttl_q        <= TTL_RESET;
      op_q         <= OP_REG;
      id_q         <= '0;
      now_q        <= '0;
      valid_q      <= '0;
      cnt_q        <= '0;
      rd_idx_q     <= '0;
      cmp_idx_q    <= '0;
      cmp_act_q    <= 1'b0;
      match_q      <= 1'b0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      removed_q    <= '0;
      done_q       <= 1'b0;
      res_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        ttl_q <= cfg_data_i;
      end

      // per-slot evaluation, one slot per cycle while the scan runs
      if (slot_live) begin
        unique case (op_q)
          OP_REG: begin
            if (id_eq) begin
              match_q <= 1'b1;
            end
          end
          OP_ACK: begin
            if (id_eq && !match_q) begin
              match_q            <= 1'b1;
              valid_q[cmp_idx_q] <= 1'b0;
              cnt_q              <= cnt_q - CNT_W'(1);
            end
          end
          OP_SWEEP: begin
            if (expired) begin
              valid_q[cmp_idx_q] <= 1'b0;
              cnt_q              <= cnt_q - CNT_W'(1);
              if (removed_q != 8'hFF) begin
                removed_q <= removed_q + 8'd1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (cmp_act_q && !valid_q[cmp_idx_q] && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= cmp_idx_q;
      end

      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            op_q         <= req_i.opcode;
            id_q         <= req_i.pdu_id;
            now_q        <= req_i.now_ms;
            rd_idx_q     <= '0;
            cmp_act_q    <= 1'b0;
            match_q      <= 1'b0;
            free_found_q <= 1'b0;
            removed_q    <= '0;
            if ((req_i.opcode == OP_REG && req_i.pdu_id != '0) ||
                req_i.opcode == OP_ACK || req_i.opcode == OP_SWEEP) begin
              state_q <= S_SCAN;
              done_q  <= 1'b0;
            end else begin
              // untracked id or unused opcode: nothing to do
              done_q <= 1'b1;
              res_q  <= '{status: ST_OK, expired_count: 8'd0};
            end
          end else begin
            done_q <= 1'b0;
          end
        end
        S_SCAN: begin
          done_q    <= 1'b0;
          cmp_act_q <= 1'b1;
          cmp_idx_q <= rd_idx_q;
          if (rd_idx_q == IDX_W'(CAPACITY - 1)) begin
            state_q <= S_LAST;
          end else begin
            rd_idx_q <= rd_idx_q + IDX_W'(1);
          end
        end
        S_LAST: begin
          // last slot is evaluated this cycle
          done_q    <= 1'b0;
          cmp_act_q <= 1'b0;
          state_q   <= S_COMMIT;
        end
        S_COMMIT: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
          if (op_q == OP_REG) begin
            if (match_q) begin
              valid_q <= '0;
              cnt_q   <= '0;
              res_q   <= '{status: ST_DUP, expired_count: 8'd0};
            end else if (cnt_q == CNT_W'(CAPACITY)) begin
              valid_q <= '0;
              cnt_q   <= '0;
              res_q   <= '{status: ST_FULL, expired_count: 8'd0};
            end else begin
              valid_q[free_idx_q] <= 1'b1;
              cnt_q               <= cnt_q + CNT_W'(1);
              res_q               <= '{status: ST_OK, expired_count: 8'd0};
            end
          end else if (op_q == OP_SWEEP) begin
            res_q <= '{status: ST_OK, expired_count: removed_q};
          end else begin
            res_q <= '{status: ST_OK, expired_count: 8'd0};
          end
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign res_o       = res_q;
  assign cfg_ready_o = 1'b1;

  // count of occupied slots stays within the table
  `AST_IMPL(a_cnt_max, 1'b1, cnt_q <= CNT_W'(CAPACITY))
  // an accepted request either starts a scan or reports at once
  `AST_NEXT(a_start_resp, start && !busy, busy || done_o)
  // a new entry only lands in a slot that was free
  `AST_IMPL(a_store_free, ram_we, free_found_q && !valid_q[free_idx_q])
  // scan evaluation only happens while the sequencer is walking the table
  `AST_IMPL(a_cmp_in_scan, cmp_act_q, state_q == S_SCAN || state_q == S_LAST)

endmodule

>>> bench/tb_pdu_ack_tracking_table_top.sv
// Self-checking testbench of the PDU ack tracking table: directed rows, then random phases.
module tb_pdu_ack_tracking_table_top
  import pat_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Opcode 3 has no operation behind it; the block must answer it with a plain ok.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Random part: PHASES phases, each one ttl setting, MIX_PER_PHASE mixed
  // transactions, plus a table fill on every even phase.
  localparam int unsigned PHASES        = 8;
  localparam int unsigned MIX_PER_PHASE = 150;

  // One item costs a full table scan plus an optional idle gap, so an idle run
  // that reaches STALL_LIMIT without any transaction means the block is stuck.
  localparam int unsigned STALL_LIMIT = 4000;

  // How a table fill ends once all CAPACITY slots are taken.
  typedef enum int {
    END_FULL,   // one more new id: table-full failure
    END_DUP,    // an id already present: duplicate wins over full
    END_SWEEP   // sweep far in the future: mass expiry
  } fill_end_e;

  // One row of the directed table. Rows with typed set carry a hand-written
  // result; the others take the predictor's.
  typedef struct {
    pat_in_t  item;
    bit       typed;
    pat_out_t want;
  } dir_row_t;

  //--------------------------------------------------------------------------
  // Clock, reset and the block's ports
  //--------------------------------------------------------------------------
  logic             clk_i;
  logic             rst_ni    = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  pat_in_t          req       = '0;
  logic             done;
  pat_out_t         res;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [TTL_W-1:0] cfg_data  = TTL_RESET;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  pdu_ack_tracking_table_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .done_o      (done),
    .res_o       (res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  //--------------------------------------------------------------------------
  // Predictor state: a shadow of the tracking table and of the ttl register.
  // Updated at the clock edge that accepts each transaction.
  //--------------------------------------------------------------------------
  logic              trk_valid [CAPACITY];
  logic [ID_W-1:0]   trk_id    [CAPACITY];
  logic [TIME_W-1:0] trk_sent  [CAPACITY];
  int                trk_count;
  logic [TTL_W-1:0]  ttl_cur;

  // Results owed by the block, oldest first.
  pat_out_t due_results [$];

  int                errors      = 0;
  int unsigned       idle_cycles = 0;
  bit                gaps_on     = 1'b1;
  logic [TIME_W-1:0] cur_time    = '0;

  // Directed rows, walked right after reset with ttl at its reset value.
  dir_row_t dir_rows [22] = '{
    // empty table: sweep and unknown ack do nothing
    '{'{OP_SWEEP,  32'd0,           48'd0},              1'b1, '{ST_OK,  8'd0}},
    '{'{OP_ACK,    32'd5,           48'd0},              1'b1, '{ST_OK,  8'd0}},
    // id 0 is never tracked
    '{'{OP_REG,    32'd0,           48'hFFFF_FFFF_FFFF}, 1'b1, '{ST_OK,  8'd0}},
    '{'{OP_REG,    32'hFFFF_FFFF,   48'd0},              1'b1, '{ST_OK,  8'd0}},
    '{'{OP_REG,    32'd1,           48'd1000},           1'b1, '{ST_OK,  8'd0}},
    // same id again: link failure, table cleared
    '{'{OP_REG,    32'hFFFF_FFFF,   48'd2000},           1'b1, '{ST_DUP, 8'd0}},
    '{'{OP_SWEEP,  32'hFFFF_FFFF,   48'hFFFF_FFFF_FFFF}, 1'b1, '{ST_OK,  8'd0}},
    '{'{OP_REG,    32'd2,           48'd10000},          1'b0, '{ST_OK,  8'd0}},
    '{'{OP_REG,    32'd3,           48'd12000},          1'b0, '{ST_OK,  8'd0}},
    '{'{OP_REG,    32'd4,           48'hFFFF_FFFF_FFFF}, 1'b0, '{ST_OK,  8'd0}},
    // age exactly ttl stays; entry from the future stays
    '{'{OP_SWEEP,  32'd0,           48'd13000},          1'b0, '{ST_OK,  8'd0}},
    // one ms later the oldest goes
    '{'{OP_SWEEP,  32'd0,           48'd13001},          1'b0, '{ST_OK,  8'd0}},
    '{'{OP_ACK,    32'd3,           48'd0},              1'b0, '{ST_OK,  8'd0}},
    '{'{OP_ACK,    32'd3,           48'd0},              1'b1, '{ST_OK,  8'd0}},
    '{'{OP_ACK,    32'd0,           48'hFFFF_FFFF_FFFF}, 1'b1, '{ST_OK,  8'd0}},
    '{'{OP_UNUSED, 32'hFFFF_FFFF,   48'hFFFF_FFFF_FFFF}, 1'b1, '{ST_OK,  8'd0}},
    // now equal to send time: age zero
    '{'{OP_SWEEP,  32'd0,           48'hFFFF_FFFF_FFFF}, 1'b0, '{ST_OK,  8'd0}},
    '{'{OP_REG,    32'hA5A5_5A5A,   48'h5A5A_A5A5_5A5A}, 1'b0, '{ST_OK,  8'd0}},
    // clock going backwards expires nothing
    '{'{OP_SWEEP,  32'd0,           48'd0},              1'b0, '{ST_OK,  8'd0}},
    '{'{OP_ACK,    32'd4,           48'd0},              1'b0, '{ST_OK,  8'd0}},
    '{'{OP_ACK,    32'hA5A5_5A5A,   48'd0},              1'b0, '{ST_OK,  8'd0}},
    '{'{OP_SWEEP,  32'd0,           48'hFFFF_FFFF_FFFF}, 1'b1, '{ST_OK,  8'd0}}
  };

  //--------------------------------------------------------------------------
  // Predictor
  //--------------------------------------------------------------------------
  function automatic void clear_trk();
    for (int i = 0; i < CAPACITY; i++) trk_valid[i] = 1'b0;
    trk_count = 0;
  endfunction

  // Slot holding id, or -1.
  function automatic int slot_of(input logic [ID_W-1:0] id);
    int hit = -1;
    for (int i = 0; i < CAPACITY; i++)
      if (hit < 0 && trk_valid[i] && trk_id[i] == id) hit = i;
    return hit;
  endfunction

  // Random occupied slot, or -1 when the table is empty.
  function automatic int pick_live();
    int base;
    int found = -1;
    base = $urandom_range(0, CAPACITY - 1);
    for (int k = 0; k < CAPACITY; k++)
      if (found < 0 && trk_valid[(base + k) % CAPACITY]) found = (base + k) % CAPACITY;
    return found;
  endfunction

  // Applies one transaction to the shadow table and returns the block's answer.
  function automatic pat_out_t pdu_table_update(input pat_in_t it);
    pat_out_t r;
    int       hit;
    int       removed = 0;
    r.status        = ST_OK;
    r.expired_count = '0;
    case (it.opcode)
      OP_REG: begin
        if (it.pdu_id != '0) begin
          hit = slot_of(it.pdu_id);
          if (hit >= 0) begin
            clear_trk();
            r.status = ST_DUP;
          end else if (trk_count >= int'(CAPACITY)) begin
            clear_trk();
            r.status = ST_FULL;
          end else begin
            // lowest free slot
            for (int i = CAPACITY - 1; i >= 0; i--) if (!trk_valid[i]) hit = i;
            trk_valid[hit] = 1'b1;
            trk_id[hit]    = it.pdu_id;
            trk_sent[hit]  = it.now_ms;
            trk_count++;
          end
        end
      end
      OP_ACK: begin
        hit = slot_of(it.pdu_id);
        if (hit >= 0) begin
          trk_valid[hit] = 1'b0;
          trk_count--;
        end
      end
      OP_SWEEP: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (trk_valid[i] && it.now_ms > trk_sent[i] &&
              (it.now_ms - trk_sent[i]) > ttl_cur) begin
            trk_valid[i] = 1'b0;
            trk_count--;
            removed++;
          end
        end
        r.expired_count = (removed > 255) ? 8'd255 : 8'(removed);
      end
      default: ;
    endcase
    return r;
  endfunction

  //--------------------------------------------------------------------------
  // Stimulus helpers
  //--------------------------------------------------------------------------
  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TIME_W-1:0];
  endfunction

  // Presents one request and holds it until the block takes it. An optional
  // idle burst comes first. The prediction is made at the accepting edge.
  // start is left high on return so back-to-back items never drop it.
  task automatic drive_item(input pat_in_t item, input bit typed, input pat_out_t want);
    int       gap;
    pat_out_t pred;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req   <= item;
    do @(posedge clk_i); while (busy);
    pred = pdu_table_update(item);
    due_results = {due_results, (typed ? want : pred)};
  endtask

  // Sender pause: stop requesting until every owed result is in.
  task automatic drain();
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  // Register write; only called with the block idle.
  task automatic write_ttl(input logic [TTL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    ttl_cur = value;
    cfg_valid <= 1'b0;
  endtask

  // One transaction of the mixed traffic. Time mostly moves forward at a
  // pace tied to ttl so sweeps catch some entries; acks mostly hit live ids.
  task automatic next_mixed(output pat_in_t it);
    int r;
    int s;
    if ($urandom_range(0, 49) == 0)
      cur_time = cur_time - $urandom_range(0, ttl_cur);
    else
      cur_time = cur_time + $urandom_range(0, ttl_cur / 4 + 8);
    it.opcode = OP_REG;
    it.now_ms = cur_time;
    // small id pool gives the occasional natural duplicate
    it.pdu_id = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(1, 700);
    r = $urandom_range(0, 99);
    if (r < 40) begin
      // plain register
    end else if (r < 43) begin
      s = pick_live();
      if (s >= 0) it.pdu_id = trk_id[s];
    end else if (r < 45) begin
      it.pdu_id = '0;
    end else if (r < 65) begin
      it.opcode = OP_ACK;
      s = pick_live();
      if (s >= 0) it.pdu_id = trk_id[s];
    end else if (r < 70) begin
      it.opcode = OP_ACK;
      it.pdu_id = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
    end else if (r < 90) begin
      it.opcode = OP_SWEEP;
      it.pdu_id = $urandom;
      if ($urandom_range(0, 9) == 0) it.now_ms = rand_time();
    end else if (r < 93) begin
      it.opcode = OP_UNUSED;
      it.pdu_id = $urandom;
      it.now_ms = rand_time();
    end else begin
      // register at an odd time: anywhere, or just below the top of the range
      it.now_ms = ($urandom_range(0, 1) != 0) ? rand_time() : {16'hFFFF, $urandom};
    end
  endtask

  // Registers new ids until every slot is taken, then ends the fill.
  task automatic fill_table(input fill_end_e how);
    pat_in_t it;
    int      s;
    while (trk_count < int'(CAPACITY)) begin
      cur_time  = cur_time + $urandom_range(0, ttl_cur / 64 + 2);
      it.opcode = OP_REG;
      it.now_ms = cur_time;
      do it.pdu_id = $urandom; while (it.pdu_id == '0 || slot_of(it.pdu_id) >= 0);
      drive_item(it, 1'b0, '0);
    end
    it.opcode = OP_REG;
    it.now_ms = cur_time;
    case (how)
      END_FULL: begin
        do it.pdu_id = $urandom; while (it.pdu_id == '0 || slot_of(it.pdu_id) >= 0);
      end
      END_DUP: begin
        s = pick_live();
        it.pdu_id = trk_id[s];
      end
      default: begin
        it.opcode = OP_SWEEP;
        it.pdu_id = $urandom;
        it.now_ms = cur_time + ttl_cur + 1 + $urandom_range(0, 1000);
        cur_time  = it.now_ms;
      end
    endcase
    drive_item(it, 1'b0, '0);
  endtask

  //--------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest owed result.
  // Ports are read at the edge that ends the strobe cycle.
  //--------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    pat_out_t want;
    if (rst_ni && done) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with none owed, expected nothing, actual status %0d count %0d",
                 $time, res.status, res.expired_count);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (want.status !== res.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, res.status);
          errors++;
        end
        if (want.expired_count !== res.expired_count) begin
          $display("%0t: expired_count mismatch, expected %0d, actual %0d",
                   $time, want.expired_count, res.expired_count);
          errors++;
        end
      end
    end
  end

  //--------------------------------------------------------------------------
  // Watchdog: counts cycles with no transaction on any channel.
  //--------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  //--------------------------------------------------------------------------
  // Main sequence
  //--------------------------------------------------------------------------
  initial begin : main_seq
    pat_in_t          it;
    logic [TTL_W-1:0] ttl_next;
    clear_trk();
    ttl_cur = TTL_RESET;

    // single reset at the start, released on a clock edge
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows at the reset ttl
    foreach (dir_rows[k]) drive_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);

    // random phases; each starts with a drain and a new ttl
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0:       ttl_next = '0;
        1:       ttl_next = '1;
        2:       ttl_next = 16'd1;
        3:       ttl_next = TTL_RESET;
        4:       ttl_next = 16'($urandom_range(2, 300));
        default: ttl_next = 16'($urandom_range(0, 65535));
      endcase
      write_ttl(ttl_next);
      // no idling in the last phase; some earlier phases run gap-free too
      gaps_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < MIX_PER_PHASE; k++) begin
        next_mixed(it);
        drive_item(it, 1'b0, '0);
      end
      if (phase % 2 == 0) fill_table(fill_end_e'((phase / 2) % 3));
    end

    // wait for the last results, then a scan's worth of quiet
    drain();
    repeat (CAPACITY + 8) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
